/* src/assert_macros.svh */
// Assertion helpers, clocked on clk_i and quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge.
`define LCFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define LCFE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/lcfe_pkg.sv */
package lcfe_pkg;

  localparam int ChanW   = 8;
  localparam int ColorW  = 24;
  localparam int PeriodW = 16;
  localparam int NumChan = 3;

  localparam logic [1:0] LAST_CHAN = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE      = 2'd0;
  localparam logic [1:0] CFG_COLOR_ONE = 2'd1;
  localparam logic [1:0] CFG_COLOR_TWO = 2'd2;
  localparam logic [1:0] CFG_PERIOD    = 2'd3;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_CONST,
    MODE_BLINK,
    MODE_GRAD
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_STEP
  } state_e;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [ChanW-1:0]   mag;
    logic [PeriodW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

  function automatic logic [ChanW-1:0] chan_of(input logic [ColorW-1:0] rgb,
                                               input logic [1:0] c);
    logic [ChanW-1:0] v;
    case (c)
      2'd0:    v = rgb[23:16];
      2'd1:    v = rgb[15:8];
      2'd2:    v = rgb[7:0];
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/lcfe_div.sv */
module lcfe_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lcfe_pkg::div_req_t                   req_i,
  output lcfe_pkg::div_rsp_t                   rsp_o,
  output logic signed [FRACTION_BITS+10-1:0]   quo_o
);

  localparam int DW   = FRACTION_BITS + lcfe_pkg::ChanW;
  localparam int QW   = FRACTION_BITS + 10;
  localparam int VW   = lcfe_pkg::PeriodW;
  localparam int CNTW = $clog2(DW + 1);

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [VW-1:0]   rem_q;
  logic [DW-1:0]   dvd_q;
  logic [VW-1:0]   dsr_q;
  logic            neg_q;

  logic [VW:0]          shifted;
  logic [VW:0]          trial;
  logic                 fits;
  logic                 last;
  logic signed [QW-1:0] mag_ext;

  assign shifted = {rem_q, dvd_q[DW-1]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign fits    = !trial[VW];
  assign last    = (cnt_q == CNTW'(DW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // one quotient bit per cycle; quotient bits shift in behind the dividend
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= {req_i.mag, {FRACTION_BITS{1'b0}}};
      dsr_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else if (busy_q && !last) begin
      rem_q <= fits ? trial[VW-1:0] : shifted[VW-1:0];
      dvd_q <= {dvd_q[DW-2:0], fits};
    end
  end

  assign mag_ext    = $signed({2'b00, dvd_q});
  assign quo_o      = neg_q ? -mag_ext : mag_ext;
  assign rsp_o.done = busy_q && last;

endmodule

/* src/led_color_fade_engine.sv */
// LED color fade engine: one RGB color per accepted tick transaction, in off, constant,
// blink (color one to black and back) or gradient (color one to color two and back) mode,
// with a triangle-wave fade of period_ticks ticks per leg. Register writes take effect at
// the next tick with restart set. A tick without restart goes straight to the step state and
// registers its result there once the output is free. A restart tick computes three signed
// per-channel steps on one shared serial divider, one quotient bit per cycle over
// FRACTION_BITS+8 bits, channel by channel, and then registers its result in the step state.
// The block takes no new transaction until the current result is registered.
`include "assert_macros.svh"

module led_color_fade_engine #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);

  localparam int QW = FRACTION_BITS + 10;
  localparam int CW = lcfe_pkg::ChanW;
  localparam int NC = lcfe_pkg::NumChan;

  lcfe_pkg::mode_e       mode_q;
  logic [23:0]           color_one_q;
  logic [23:0]           color_two_q;
  logic [15:0]           period_q;

  lcfe_pkg::mode_e       run_mode_q;
  logic [23:0]           run_one_q;
  logic [23:0]           run_target_q;
  logic [15:0]           run_period_q;

  lcfe_pkg::state_e      state_q, state_d;
  logic [1:0]            chan_q, chan_d;
  logic [15:0]           tick_q;
  logic                  rising_q;
  logic signed [QW-1:0]  level_q [NC];
  logic signed [QW-1:0]  step_q  [NC];

  logic                  out_valid_q;
  logic [CW-1:0]         out_q   [NC];

  logic                  accept;
  logic                  out_free;
  logic                  step_en;
  logic                  fading;
  logic                  flip;
  logic                  rising_nxt;
  logic [15:0]           tick_nxt;
  logic signed [QW-1:0]  lvl_nxt [NC];
  logic [CW-1:0]         res     [NC];
  logic [CW-1:0]         ch_a, ch_t;

  lcfe_pkg::div_req_t    div_req;
  lcfe_pkg::div_rsp_t    div_rsp;
  logic signed [QW-1:0]  div_quo;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= lcfe_pkg::MODE_OFF;
      color_one_q <= '0;
      color_two_q <= '0;
      period_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcfe_pkg::CFG_MODE:      mode_q      <= lcfe_pkg::mode_e'(cfg_wdata_i[1:0]);
        lcfe_pkg::CFG_COLOR_ONE: color_one_q <= cfg_wdata_i;
        lcfe_pkg::CFG_COLOR_TWO: color_two_q <= cfg_wdata_i;
        lcfe_pkg::CFG_PERIOD:    period_q    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // divider operands for the channel in progress
  assign ch_a = lcfe_pkg::chan_of(run_one_q, chan_q);
  assign ch_t = lcfe_pkg::chan_of(run_target_q, chan_q);

  always_comb begin
    div_req.start   = (state_q == lcfe_pkg::ST_LOAD);
    div_req.neg     = (ch_t < ch_a);
    div_req.mag     = div_req.neg ? (ch_a - ch_t) : (ch_t - ch_a);
    div_req.divisor = run_period_q;
  end

  lcfe_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp),
    .quo_o (div_quo)
  );

  // tick datapath
  always_comb begin
    fading     = (run_mode_q == lcfe_pkg::MODE_BLINK || run_mode_q == lcfe_pkg::MODE_GRAD)
                 && (run_period_q != '0);
    flip       = (tick_q == '0) || (tick_q >= run_period_q);
    rising_nxt = rising_q ^ flip;
    tick_nxt   = rising_nxt ? tick_q + 16'd1 : tick_q - 16'd1;
    for (int c = 0; c < NC; c++) begin
      lvl_nxt[c] = rising_q ? level_q[c] + step_q[c] : level_q[c] - step_q[c];
      if (run_mode_q == lcfe_pkg::MODE_OFF) begin
        res[c] = '0;
      end else if (!fading) begin
        res[c] = lcfe_pkg::chan_of(run_one_q, 2'(c));
      end else if (lvl_nxt[c][QW-1]) begin
        res[c] = '0;
      end else if (|lvl_nxt[c][QW-2:FRACTION_BITS+CW]) begin
        res[c] = '1;
      end else begin
        res[c] = lvl_nxt[c][FRACTION_BITS+CW-1:FRACTION_BITS];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    step_en = 1'b0;
    case (state_q)
      lcfe_pkg::ST_IDLE: begin
        if (accept) begin
          chan_d  = '0;
          state_d = restart_i ? lcfe_pkg::ST_LOAD : lcfe_pkg::ST_STEP;
        end
      end
      lcfe_pkg::ST_LOAD: begin
        state_d = lcfe_pkg::ST_DIV;
      end
      lcfe_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (chan_q == lcfe_pkg::LAST_CHAN) begin
            state_d = lcfe_pkg::ST_STEP;
          end else begin
            chan_d  = chan_q + 2'd1;
            state_d = lcfe_pkg::ST_LOAD;
          end
        end
      end
      lcfe_pkg::ST_STEP: begin
        if (out_free) begin
          step_en = 1'b1;
          state_d = lcfe_pkg::ST_IDLE;
        end
      end
      default: state_d = lcfe_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != lcfe_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lcfe_pkg::ST_IDLE;
      chan_q       <= '0;
      run_mode_q   <= lcfe_pkg::MODE_OFF;
      tick_q       <= 16'd1;
      rising_q     <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
      if (accept && restart_i) begin
        run_mode_q <= mode_q;
        tick_q     <= 16'd1;
        rising_q   <= 1'b1;
      end else if (step_en && fading) begin
        tick_q   <= tick_nxt;
        rising_q <= rising_nxt;
      end
      if (step_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && restart_i) begin
      run_one_q    <= color_one_q;
      run_target_q <= (mode_q == lcfe_pkg::MODE_BLINK) ? '0 : color_two_q;
      run_period_q <= period_q;
      for (int c = 0; c < NC; c++) begin
        level_q[c] <= QW'({lcfe_pkg::chan_of(color_one_q, 2'(c)), {FRACTION_BITS{1'b0}}});
      end
    end else if (step_en && fading) begin
      for (int c = 0; c < NC; c++) begin
        level_q[c] <= lvl_nxt[c];
      end
    end
    if (state_q == lcfe_pkg::ST_DIV && div_rsp.done) begin
      step_q[chan_q] <= (run_period_q == '0) ? '0 : div_quo;
    end
    if (step_en) begin
      for (int c = 0; c < NC; c++) begin
        out_q[c] <= res[c];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = out_q[0];
  assign green_o     = out_q[1];
  assign blue_o      = out_q[2];

  `LCFE_ASSERT(a_done_in_div, div_rsp.done |-> state_q == lcfe_pkg::ST_DIV,
               "divider finished outside the division phase")
  `LCFE_ASSERT(a_restart_loads, (accept && restart_i) |=>
               (state_q == lcfe_pkg::ST_LOAD && chan_q == 2'd0),
               "restart did not start the division sequence at the first channel")
  `LCFE_ASSERT(a_out_from_step, $rose(out_valid_q) |-> $past(state_q == lcfe_pkg::ST_STEP),
               "result appeared without a tick step")
  `LCFE_NEVER(a_chan_range, chan_q > lcfe_pkg::LAST_CHAN, "channel counter out of range")

endmodule
